[sv/slle_pkg.sv]
// slle_pkg: shared types and constants of the static linked list engine
// used by slle_cell, slle_ctrl, static_linked_list_engine_unit and its checker
// no dependencies
package slle_pkg;

  localparam int SLOTS_DEF   = 64;
  localparam int REQ_W       = 3;
  localparam int POS_W       = 6;
  localparam int VAL_W       = 32;
  localparam int ST_W        = 2;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 48;

  // input word layout
  localparam int S_REQ_LSB   = 0;
  localparam int S_POS_LSB   = S_REQ_LSB + REQ_W;
  localparam int S_VAL_LSB   = S_POS_LSB + POS_W;

  // output word layout
  localparam int M_ST_LSB    = 0;
  localparam int M_ELEM_LSB  = M_ST_LSB + ST_W;
  localparam int M_EPOS_LSB  = M_ELEM_LSB + VAL_W;
  localparam int M_CNT_LSB   = M_EPOS_LSB + POS_W;
  localparam int M_USED_W    = M_CNT_LSB + POS_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_MODIFY = 3'd3,
    REQ_DUMP   = 3'd4
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } fsm_e;

  // broadcast command from the controller to every cell
  typedef struct packed {
    cell_op_e                op;
    logic [POS_W-1:0]        idx;       // 0-based target cell
    logic [POS_W-1:0]        last_idx;  // last occupied cell, for rotation
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

[sv/slle_cell.sv]
// slle_cell: one list element of the cell chain, holds the value at one position
// depends on slle_pkg
module slle_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk_i,
  input  slle_pkg::cell_cmd_t               cmd_i,
  input  logic signed [slle_pkg::VAL_W-1:0] left_i,
  input  logic signed [slle_pkg::VAL_W-1:0] right_i,
  input  logic signed [slle_pkg::VAL_W-1:0] head_i,
  output logic signed [slle_pkg::VAL_W-1:0] value_o
);

  localparam logic [slle_pkg::POS_W-1:0] MyIdx = slle_pkg::POS_W'(IDX);

  logic signed [slle_pkg::VAL_W-1:0] value_d, value_q;

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      slle_pkg::CELL_INSERT: begin
        if (MyIdx == cmd_i.idx) begin
          value_d = cmd_i.value;
        end else if (MyIdx > cmd_i.idx) begin
          value_d = left_i;
        end
      end
      slle_pkg::CELL_DELETE: begin
        if (MyIdx >= cmd_i.idx) begin
          value_d = right_i;
        end
      end
      slle_pkg::CELL_WRITE: begin
        if (MyIdx == cmd_i.idx) begin
          value_d = cmd_i.value;
        end
      end
      slle_pkg::CELL_ROTATE: begin
        // front element wraps to the back of the occupied part
        if (MyIdx == cmd_i.last_idx) begin
          value_d = head_i;
        end else if (MyIdx < cmd_i.last_idx) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

[sv/slle_ctrl.sv]
// slle_ctrl: request holding register, sequencer and output register of the engine
// depends on slle_pkg; drives the broadcast command of the slle_cell chain
module slle_ctrl #(
  parameter int SLOTS = slle_pkg::SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [slle_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [slle_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic signed [slle_pkg::VAL_W-1:0]   head_i,
  output slle_pkg::cell_cmd_t                 cmd_o
);

  localparam logic [slle_pkg::POS_W-1:0] Cap = slle_pkg::POS_W'(SLOTS - 2);

  // held request
  logic                              req_valid_q;
  logic [slle_pkg::REQ_W-1:0]        req_type_q;
  logic [slle_pkg::POS_W-1:0]        req_pos_q;
  logic signed [slle_pkg::VAL_W-1:0] req_val_q;
  logic                              req_done;

  slle_pkg::fsm_e                    state_d, state_q;
  logic [slle_pkg::POS_W-1:0]        cnt_d, cnt_q;
  logic [slle_pkg::POS_W-1:0]        dump_idx_d, dump_idx_q;

  // output register
  logic                              out_valid_d, out_valid_q;
  slle_pkg::status_e                 out_st_d, out_st_q;
  logic signed [slle_pkg::VAL_W-1:0] out_elem_d, out_elem_q;
  logic [slle_pkg::POS_W-1:0]        out_pos_d, out_pos_q;
  logic [slle_pkg::POS_W-1:0]        out_cnt_d, out_cnt_q;
  logic                              out_last_d, out_last_q;
  logic                              load_out;
  logic                              out_free;

  // single-step request decode
  slle_pkg::status_e                 ex_st;
  slle_pkg::cell_op_e                ex_op;
  logic [slle_pkg::POS_W-1:0]        ex_idx;
  logic [slle_pkg::POS_W-1:0]        ex_cnt;
  logic [slle_pkg::POS_W:0]          cnt_ext;
  logic [slle_pkg::POS_W:0]          pos_ext;
  logic                              is_dump;
  logic                              dump_last;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign is_dump   = (req_type_q == slle_pkg::REQ_DUMP);
  assign dump_last = ((dump_idx_q + slle_pkg::POS_W'(1)) == cnt_q);
  assign cnt_ext   = {1'b0, cnt_q};
  assign pos_ext   = {1'b0, req_pos_q};

  always_comb begin
    ex_st  = slle_pkg::ST_OK;
    ex_op  = slle_pkg::CELL_HOLD;
    ex_idx = req_pos_q - slle_pkg::POS_W'(1);
    ex_cnt = cnt_q;
    case (req_type_q)
      slle_pkg::REQ_APPEND: begin
        if (cnt_q >= Cap) begin
          ex_st = slle_pkg::ST_FULL;
        end else begin
          ex_op  = slle_pkg::CELL_INSERT;
          ex_idx = cnt_q;
          ex_cnt = cnt_q + slle_pkg::POS_W'(1);
        end
      end
      slle_pkg::REQ_INSERT: begin
        if (cnt_q >= Cap) begin
          ex_st = slle_pkg::ST_FULL;
        end else if (req_pos_q == '0 || pos_ext > cnt_ext + 7'd1) begin
          ex_st = slle_pkg::ST_RANGE;
        end else begin
          ex_op  = slle_pkg::CELL_INSERT;
          ex_cnt = cnt_q + slle_pkg::POS_W'(1);
        end
      end
      slle_pkg::REQ_DELETE: begin
        if (cnt_q == '0) begin
          ex_st = slle_pkg::ST_EMPTY;
        end else if (req_pos_q == '0 || req_pos_q > cnt_q) begin
          ex_st = slle_pkg::ST_RANGE;
        end else begin
          ex_op  = slle_pkg::CELL_DELETE;
          ex_cnt = cnt_q - slle_pkg::POS_W'(1);
        end
      end
      slle_pkg::REQ_MODIFY: begin
        if (cnt_q == '0) begin
          ex_st = slle_pkg::ST_EMPTY;
        end else if (req_pos_q == '0 || req_pos_q > cnt_q) begin
          ex_st = slle_pkg::ST_RANGE;
        end else begin
          ex_op = slle_pkg::CELL_WRITE;
        end
      end
      default: ex_st = slle_pkg::ST_OK;  // unknown codes are no-ops
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slle_pkg::FSM_IDLE: begin
        if (req_valid_q && out_free && is_dump && cnt_q != '0) begin
          state_d = slle_pkg::FSM_DUMP;
        end
      end
      slle_pkg::FSM_DUMP: begin
        if (out_free && dump_last) begin
          state_d = slle_pkg::FSM_IDLE;
        end
      end
      default: state_d = slle_pkg::FSM_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_o.op       = slle_pkg::CELL_HOLD;
    cmd_o.idx      = ex_idx;
    cmd_o.last_idx = cnt_q - slle_pkg::POS_W'(1);
    cmd_o.value    = req_val_q;
    load_out       = 1'b0;
    req_done       = 1'b0;
    cnt_d          = cnt_q;
    dump_idx_d     = dump_idx_q;
    out_st_d       = out_st_q;
    out_elem_d     = out_elem_q;
    out_pos_d      = out_pos_q;
    out_cnt_d      = out_cnt_q;
    out_last_d     = out_last_q;
    case (state_q)
      slle_pkg::FSM_IDLE: begin
        if (req_valid_q && out_free) begin
          if (is_dump) begin
            dump_idx_d = '0;
            if (cnt_q == '0) begin
              load_out   = 1'b1;
              req_done   = 1'b1;
              out_st_d   = slle_pkg::ST_EMPTY;
              out_elem_d = '0;
              out_pos_d  = '0;
              out_cnt_d  = '0;
              out_last_d = 1'b1;
            end
          end else begin
            load_out   = 1'b1;
            req_done   = 1'b1;
            cmd_o.op   = ex_op;
            cnt_d      = ex_cnt;
            out_st_d   = ex_st;
            out_elem_d = '0;
            out_pos_d  = '0;
            out_cnt_d  = ex_cnt;
            out_last_d = 1'b1;
          end
        end
      end
      slle_pkg::FSM_DUMP: begin
        if (out_free) begin
          load_out   = 1'b1;
          cmd_o.op   = slle_pkg::CELL_ROTATE;
          dump_idx_d = dump_idx_q + slle_pkg::POS_W'(1);
          req_done   = dump_last;
          out_st_d   = slle_pkg::ST_OK;
          out_elem_d = head_i;
          out_pos_d  = dump_idx_q + slle_pkg::POS_W'(1);
          out_cnt_d  = cnt_q;
          out_last_d = dump_last;
        end
      end
      default: cmd_o.op = slle_pkg::CELL_HOLD;
    endcase
  end

  assign out_valid_d   = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  assign s_axis_tready = !req_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slle_pkg::FSM_IDLE;
      cnt_q       <= '0;
      dump_idx_q  <= '0;
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
      if (s_axis_tvalid && s_axis_tready) begin
        req_valid_q <= 1'b1;
      end else if (req_done) begin
        req_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_type_q <= s_axis_tdata[slle_pkg::S_REQ_LSB +: slle_pkg::REQ_W];
      req_pos_q  <= s_axis_tdata[slle_pkg::S_POS_LSB +: slle_pkg::POS_W];
      req_val_q  <= s_axis_tdata[slle_pkg::S_VAL_LSB +: slle_pkg::VAL_W];
    end
    out_st_q   <= out_st_d;
    out_elem_q <= out_elem_d;
    out_pos_q  <= out_pos_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(slle_pkg::M_TDATA_W - slle_pkg::M_USED_W)'(0),
                          out_cnt_q, out_pos_q, out_elem_q, out_st_q};

endmodule

[sv/static_linked_list_engine_unit.sv]
// static_linked_list_engine_unit: top level, a chain of value cells under one sequencer
// depends on slle_pkg, slle_cell and slle_ctrl
//
//   channel   dir   handshake                       payload
//   s_axis    in    s_axis_tvalid / s_axis_tready   tdata: req_type, position, value
//   m_axis    out   m_axis_tvalid / m_axis_tready   tdata: status, element, element_pos,
//                                                  entry_count; tlast: last
//
// the list lives in a row of SLOTS-2 cells, cell k holding the element at position k+1
// append, insert, delete and modify shift or write the row as their status word is
// registered, once the request is held and the output register is free; a dump enters the
// dump state, then sends one element per cycle while the output is free (up to SLOTS-2),
// rotating the row by one cell per element so that the front cell feeds the output
// reset empties the list at once; cell contents are not cleared and need no pass
// a stalled output holds the sequencer; one further request word is taken meanwhile
module static_linked_list_engine_unit #(
  parameter int SLOTS = slle_pkg::SLOTS_DEF  // 4 to 64, the list keeps SLOTS-2 elements
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] req_type, [8:3] position, [40:9] value, [47:41] zero
  input  logic [slle_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] status, [33:2] element, [39:34] element_pos, [45:40] entry_count, [47:46] zero
  output logic [slle_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // last word caused by a request
  output logic                           m_axis_tlast
);

  localparam int Cells = SLOTS - 2;

  slle_pkg::cell_cmd_t               cmd;
  logic signed [slle_pkg::VAL_W-1:0] cell_val [Cells];

  // sequencer, request register and output register
  slle_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .head_i       (cell_val[0]),
    .cmd_o        (cmd)
  );

  // row of cells, each sees both neighbors and the front cell for wraparound
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    logic signed [slle_pkg::VAL_W-1:0] left, right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_val[g-1];
    end

    if (g == Cells - 1) begin : g_final
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_val[g+1];
    end

    slle_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .head_i (cell_val[0]),
      .value_o(cell_val[g])
    );
  end

endmodule

[sv/slle_checker.sv]
// slle_checker: port-level assertions for static_linked_list_engine_unit, with its bind
// depends on slle_pkg
module slle_checker #(
  parameter int SLOTS = slle_pkg::SLOTS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [slle_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  localparam logic [slle_pkg::POS_W-1:0] Cap = slle_pkg::POS_W'(SLOTS - 2);

  logic [slle_pkg::ST_W-1:0]  st;
  logic [slle_pkg::POS_W-1:0] epos;
  logic [slle_pkg::POS_W-1:0] cnt;

  assign st   = m_axis_tdata[slle_pkg::M_ST_LSB +: slle_pkg::ST_W];
  assign epos = m_axis_tdata[slle_pkg::M_EPOS_LSB +: slle_pkg::POS_W];
  assign cnt  = m_axis_tdata[slle_pkg::M_CNT_LSB +: slle_pkg::POS_W];

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // list never grows past capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt <= Cap)
    else $error("entry_count above capacity");

  // only dump words come without last, and they carry an ok element
  a_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> st == slle_pkg::ST_OK && epos != '0)
    else $error("non-final word is not a dump element");

  // an empty report comes only from an empty list
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == slle_pkg::ST_EMPTY |-> cnt == '0 && m_axis_tlast)
    else $error("empty status with elements present");

  // dump positions climb by one within a run
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid || epos == $past(epos) + slle_pkg::POS_W'(1))
    else $error("dump positions out of order");

endmodule

bind static_linked_list_engine_unit slle_checker #(
  .SLOTS(SLOTS)
) u_slle_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for static_linked_list_engine_unit, stream words in and out
// keeps a shadow copy of the list to predict every output word, stalls both sides at random
// depends on slle_pkg and static_linked_list_engine_unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slle_pkg::*;

  localparam int CAPACITY = SLOTS_DEF - 2;
  localparam int HOLD_CYCLES = 400;
  // request codes the engine treats as a no-op
  localparam logic [REQ_W-1:0] REQ_NOP_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_NOP_HI = 3'd7;

  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] element;
    logic [POS_W-1:0]        element_pos;
    logic [POS_W-1:0]        entry_count;
    logic                    last;
  } list_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  logic signed [VAL_W-1:0] shadow_list[$];   // element values, position 1 first
  list_word_t              expected_words[$];
  list_word_t              oldest;
  int                      errors = 0;

  // sender burst state
  bit steady_sender = 1'b0;
  int burst_left = 0;

  // receiver stall state
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_phase_left = 0;
  int rx_tick = 0;

  static_linked_list_engine_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // works out the output words of one accepted request and updates the shadow list
  task automatic predict_list_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                                      input logic signed [VAL_W-1:0] val);
    int cnt;
    int eff_pos;
    list_word_t w;
    cnt = shadow_list.size();
    eff_pos = pos;
    w = '{status: ST_OK, element: '0, element_pos: '0, entry_count: '0, last: 1'b1};
    case (req)
      REQ_DUMP: begin
        if (cnt == 0) begin
          w.status = ST_EMPTY;
          expected_words.push_back(w);
        end else begin
          for (int k = 0; k < cnt; k++) begin
            w.element = shadow_list[k];
            w.element_pos = POS_W'(k + 1);
            w.entry_count = POS_W'(cnt);
            w.last = (k == cnt - 1);
            expected_words.push_back(w);
          end
        end
        return;
      end
      REQ_APPEND, REQ_INSERT: begin
        if (req == REQ_APPEND) eff_pos = cnt + 1;
        // fullness wins over a bad position
        if (cnt >= CAPACITY) w.status = ST_FULL;
        else if (eff_pos < 1 || eff_pos > cnt + 1) w.status = ST_RANGE;
        else shadow_list.insert(eff_pos - 1, val);
      end
      REQ_DELETE, REQ_MODIFY: begin
        if (cnt == 0) w.status = ST_EMPTY;
        else if (eff_pos < 1 || eff_pos > cnt) w.status = ST_RANGE;
        else if (req == REQ_MODIFY) shadow_list[eff_pos - 1] = val;
        else shadow_list.delete(eff_pos - 1);
      end
      default: ;  // unused codes change nothing
    endcase
    w.entry_count = POS_W'(shadow_list.size());
    expected_words.push_back(w);
  endtask

  // offers one request word, with a random gap between bursts unless the sender is steady
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    int gap;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 8);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_axis_tdata <= {{(S_TDATA_W - S_VAL_LSB - VAL_W){1'b0}}, val, pos, req};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_list_request(req, pos, val);
  endtask

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_position(input int lo, input int hi);
    if (hi < lo) return POS_W'(lo);
    return POS_W'($urandom_range(lo, hi));
  endfunction

  // dump, delete, modify and insert on an empty list, plus the unused codes
  task automatic test_empty_list();
    send_word(REQ_DUMP, '0, '0);
    send_word(REQ_DELETE, 6'd1, '0);
    send_word(REQ_MODIFY, '0, '1);              // empty is reported before range
    send_word(REQ_INSERT, '0, 32'sh1234_5678);  // position zero
    send_word(REQ_INSERT, 6'd2, 32'sh1234_5678);
    for (int code = REQ_NOP_LO; code <= REQ_NOP_HI; code++)
      send_word(REQ_W'(code), '1, '1);
    send_word(REQ_INSERT, 6'd1, 32'sh8000_0000);  // position count+1 acts as append
  endtask

  // front, middle and tail cases of insert, modify and delete
  task automatic test_positional_ops();
    send_word(REQ_APPEND, '0, 32'sh7FFF_FFFF);
    send_word(REQ_APPEND, '1, '0);
    send_word(REQ_APPEND, '0, '1);
    send_word(REQ_INSERT, 6'd1, 32'shAAAA_AAAA);
    send_word(REQ_INSERT, 6'd6, 32'sh5555_5555);
    send_word(REQ_INSERT, 6'd3, 32'sd12345);
    send_word(REQ_MODIFY, 6'd1, 32'sh0F0F_0F0F);
    send_word(REQ_MODIFY, 6'd7, 32'shF0F0_F0F0);
    send_word(REQ_MODIFY, 6'd8, '1);
    send_word(REQ_DELETE, '1, '0);
    send_word(REQ_DELETE, '0, '0);
    send_word(REQ_DUMP, '0, '0);
    send_word(REQ_DELETE, 6'd7, '0);    // the tail moves back
    send_word(REQ_DELETE, 6'd1, '0);
    send_word(REQ_DELETE, 6'd3, '0);
    send_word(REQ_APPEND, '0, 32'sd77);  // append after the tail was removed
    send_word(REQ_DUMP, '0, '0);
  endtask

  // the receiver holds off for a long stretch while the sender keeps offering words
  task automatic test_output_stall();
    hold_asked++;
    steady_sender = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i == 5) send_word(REQ_DUMP, '0, '0);
      else if (i % 3 == 0) send_word(REQ_INSERT, random_position(1, shadow_list.size() + 1),
                                     random_value());
      else send_word(REQ_APPEND, '0, random_value());
    end
    steady_sender = 1'b0;
  endtask

  // grows the list to capacity, knocks on the full list, then shrinks it again
  task automatic test_full_list();
    while (shadow_list.size() < CAPACITY) begin
      if ($urandom_range(0, 2) == 0)
        send_word(REQ_INSERT, random_position(1, shadow_list.size() + 1), random_value());
      else
        send_word(REQ_APPEND, '0, random_value());
    end
    send_word(REQ_APPEND, '0, random_value());
    send_word(REQ_INSERT, 6'd1, random_value());
    send_word(REQ_INSERT, '0, random_value());  // full is reported before range
    send_word(REQ_INSERT, '1, random_value());
    send_word(REQ_MODIFY, POS_W'(CAPACITY), random_value());
    send_word(REQ_DUMP, '0, '0);
    while (shadow_list.size() > 24) begin
      if ($urandom_range(0, 4) == 0)
        send_word(REQ_MODIFY, random_position(1, shadow_list.size()), random_value());
      send_word(REQ_DELETE, random_position(1, shadow_list.size()), '0);
    end
  endtask

  // mostly well-formed requests on the live list, some noise with any code and position
  task automatic test_random_mix(input int n_words);
    int pick;
    int cnt;
    repeat (n_words) begin
      cnt = shadow_list.size();
      pick = $urandom_range(0, 99);
      if (pick < 28)
        send_word(REQ_APPEND, random_position(0, 63), random_value());
      else if (pick < 48)
        send_word(REQ_INSERT, random_position(1, cnt + 1), random_value());
      else if (pick < 64)
        send_word(REQ_DELETE, random_position(1, cnt), random_value());
      else if (pick < 80)
        send_word(REQ_MODIFY, random_position(1, cnt), random_value());
      else if (pick < 86)
        send_word(REQ_DUMP, random_position(0, 63), random_value());
      else
        send_word(REQ_W'($urandom_range(0, 7)), random_position(0, 63), random_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_positional_ops();
    test_output_stall();
    test_full_list();
    test_random_mix(45);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    // let any stray word show up
    repeat (2 * SLOTS_DEF) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // receiver: long hold on request, otherwise a random stall pattern that changes from phase to phase
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_phase_left <= $urandom_range(8, 80);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 2) == 0);
        default: m_axis_tready <= (rx_tick % 5 < 2);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // compares every accepted output word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual tdata %0h tlast %0b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        oldest = expected_words.pop_front();
        check_field("status", oldest.status, m_axis_tdata[M_ST_LSB +: ST_W]);
        check_field("element", oldest.element[VAL_W-1:0], m_axis_tdata[M_ELEM_LSB +: VAL_W]);
        check_field("element_pos", oldest.element_pos, m_axis_tdata[M_EPOS_LSB +: POS_W]);
        check_field("entry_count", oldest.entry_count, m_axis_tdata[M_CNT_LSB +: POS_W]);
        check_field("padding", '0, m_axis_tdata[M_TDATA_W-1:M_USED_W]);
        check_field("last", oldest.last, m_axis_tlast);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
sv/slle_pkg.sv
sv/slle_cell.sv
sv/slle_ctrl.sv
sv/static_linked_list_engine_unit.sv
sv/slle_checker.sv
tb/sv/tb_top.sv
